/* rtl/assert_macros.svh */
// Assertion macros, used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_SYNC(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   `ASSERT_SYNC(lbl, clk, rst, !(cond), msg)

`endif

/* rtl/lfps_pkg.sv */
// Package: constants, codes and control structs of the line follower steering block.
`default_nettype none

package lfps_pkg;

   localparam int SENSOR_COUNT    = 5;
   localparam int READING_BITS    = 10;
   localparam int SENSOR_IDX_BITS = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

   localparam int Q_BITS      = 12;
   localparam int FULL_SCALE  = 1 << Q_BITS;
   localparam int VALUE_BITS  = Q_BITS + 1;
   localparam int DRIVE_BITS  = 13;
   localparam int POS_BITS    = 14;
   localparam int GAIN_BITS   = 16;
   localparam int COUNT_BITS  = 3;
   localparam int LAP_BITS    = 8;
   localparam int ACTION_BITS = 2;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   // centroid geometry: weight (i+1)*WEIGHT_STEP, centre CENTRE_POS, span HALF_SPAN
   localparam int WEIGHT_STEP = 1000;
   localparam int CENTRE_POS  = 3000;
   localparam int HALF_SPAN   = 2000;
   localparam int CENTRE_IDX  = CENTRE_POS / WEIGHT_STEP - 1;
   localparam int SPAN_RATIO  = HALF_SPAN / WEIGHT_STEP;
   localparam int HI_OFF      = SENSOR_COUNT - 1 - CENTRE_IDX;
   localparam int MAX_OFF     = (CENTRE_IDX > HI_OFF) ? CENTRE_IDX : HI_OFF;
   localparam int OFF_BITS    = $clog2(MAX_OFF + 1) + 1;

   localparam int LIT_BITS  = $clog2(SENSOR_COUNT + 1);
   localparam int LIT_MAX   = (1 << COUNT_BITS) - 1;
   localparam int RUN_LIMIT = 3;
   localparam int LAP_LIT   = 4;

   localparam int SUM_BITS  = $clog2(SENSOR_COUNT * FULL_SCALE + 1);
   localparam int TSUM_BITS = $clog2(MAX_OFF * SENSOR_COUNT * FULL_SCALE + 1) + 1;

   // position divide: q = floor((|T|*2*FS + R*S) / (2*R*S))
   localparam int POSQ_BITS    = $clog2(MAX_OFF * FULL_SCALE / SPAN_RATIO + 2);
   localparam int PNUM_BITS    = TSUM_BITS + Q_BITS + 2;
   localparam int DEN_POS_BITS = $clog2(2 * SPAN_RATIO * SENSOR_COUNT * FULL_SCALE + 1);

   localparam int DIV_D_BITS    = (READING_BITS > DEN_POS_BITS) ? READING_BITS : DEN_POS_BITS;
   localparam int DIV_FEED_BITS = (Q_BITS > POSQ_BITS) ? Q_BITS : POSQ_BITS;
   localparam int DIV_CNT_BITS  = $clog2(DIV_FEED_BITS + 1);

   localparam int MUL_TERMS    = 4;
   localparam int MUL_SEL_BITS = 2;
   localparam int MUL_CNT_BITS = $clog2(MUL_TERMS + 1);
   localparam int MUL_B_BITS   = POS_BITS + 2;
   localparam int PROD_BITS    = GAIN_BITS + MUL_B_BITS;
   localparam int ACC_BITS     = PROD_BITS + 2;
   localparam int PID_BITS     = ACC_BITS - Q_BITS + 1;
   localparam int DRV_BITS     = PID_BITS + 2;

   localparam logic [ACTION_BITS-1:0] ACT_CONTROL = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_FLOOR   = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_LINE    = 2'd2;
   localparam logic [ACTION_BITS-1:0] ACT_UNUSED  = 2'd3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN_P    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN_I    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN_D    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN_R    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BASE      = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_THRESHOLD = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DARK      = 3'd6;

   localparam logic [MUL_SEL_BITS-1:0] MUL_P = 2'd0;
   localparam logic [MUL_SEL_BITS-1:0] MUL_I = 2'd1;
   localparam logic [MUL_SEL_BITS-1:0] MUL_D = 2'd2;
   localparam logic [MUL_SEL_BITS-1:0] MUL_R = 2'd3;

   localparam logic signed [GAIN_BITS-1:0] RESET_GAIN_P    = 16'sd2048;
   localparam logic [DRIVE_BITS-1:0]       RESET_BASE      = 13'd2458;
   localparam logic [DRIVE_BITS-1:0]       RESET_THRESHOLD = 13'd2048;

   typedef struct packed {
      logic                       load_item;
      logic                       capture;
      logic [SENSOR_IDX_BITS-1:0] sensor_sel;
      logic                       norm_div_start;
      logic                       norm_acc;
      logic                       decide;
      logic                       pos_div_start;
      logic                       pos_done;
      logic                       mul_issue;
      logic                       mul_accum;
      logic [MUL_SEL_BITS-1:0]    mul_sel;
      logic                       round;
      logic                       out_load;
   } cmd_type;

   typedef struct packed {
      logic [ACTION_BITS-1:0] action;
      logic                   need_div;
      logic                   div_busy;
      logic                   run_ok;
   } status_type;

endpackage

`default_nettype wire

/* rtl/line_follower_pid_steering.sv */
// Top level of the line follower steering block: controller plus datapath.
//
// Request channel (req_*): one beat carries an action and one averaged reading per
// sensor. Action floor or line stores the readings as calibration; action control
// runs a steering step; the unused code is answered without effect.
// Response channel (rsp_*): exactly one beat per request, in order.
// Configuration (csr_*): gains, base speed, threshold and line polarity; write only
// while the block is idle, one register per cycle with csr_write_enable high.
// Sequence: a capture stores the readings and then offers its response. A control
// step runs a setup state, then per sensor a check and, where needed, a 12-bit
// restoring divide and an accumulate, then a decide state; when a position is
// computed, a 13-bit position divide, four shared multiplies and rounding follow,
// and the response is loaded last. The single divider is shared by both divides;
// one item is worked on at a time.
// The response sits in an output register, so a new request is taken while the
// previous response still waits; a stalled receiver holds the block only at the
// point where its next response is ready.
// Reset (synchronous, active high) restores register defaults and clears the
// calibration, position history, lit history and lap counter.
`default_nettype none
`include "assert_macros.svh"

module line_follower_pid_steering (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_enable,
   input  wire logic [lfps_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [lfps_pkg::CSR_DATA_BITS-1:0]  csr_write_data,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [lfps_pkg::ACTION_BITS-1:0]    req_action,
   input  wire logic [lfps_pkg::READING_BITS-1:0]   req_reading_0,
   input  wire logic [lfps_pkg::READING_BITS-1:0]   req_reading_1,
   input  wire logic [lfps_pkg::READING_BITS-1:0]   req_reading_2,
   input  wire logic [lfps_pkg::READING_BITS-1:0]   req_reading_3,
   input  wire logic [lfps_pkg::READING_BITS-1:0]   req_reading_4,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_drive_valid,
   output logic [lfps_pkg::DRIVE_BITS-1:0]          rsp_left_drive,
   output logic [lfps_pkg::DRIVE_BITS-1:0]          rsp_right_drive,
   output logic signed [lfps_pkg::POS_BITS-1:0]     rsp_line_position,
   output logic [lfps_pkg::COUNT_BITS-1:0]          rsp_lit_count,
   output logic [lfps_pkg::LAP_BITS-1:0]            rsp_lap_total,
   output logic                                     rsp_lap_pulse
);

   lfps_pkg::cmd_type    cmd;
   lfps_pkg::status_type status;
   logic [lfps_pkg::READING_BITS-1:0] reading [lfps_pkg::SENSOR_COUNT];

   // sensor ports gathered into one array, sensor 0 first
   assign reading[0] = req_reading_0;
   assign reading[1] = req_reading_1;
   assign reading[2] = req_reading_2;
   assign reading[3] = req_reading_3;
   assign reading[4] = req_reading_4;

   lfps_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   lfps_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_action        (req_action),
      .req_reading       (reading),
      .cmd               (cmd),
      .status            (status),
      .rsp_drive_valid   (rsp_drive_valid),
      .rsp_left_drive    (rsp_left_drive),
      .rsp_right_drive   (rsp_right_drive),
      .rsp_line_position (rsp_line_position),
      .rsp_lit_count     (rsp_lit_count),
      .rsp_lap_total     (rsp_lap_total),
      .rsp_lap_pulse     (rsp_lap_pulse)
   );

   // a waiting response beat is never overwritten
   `ASSERT_NEVER(a_no_overwrite, clock, reset, cmd.out_load && rsp_valid && !rsp_ready, "response overwritten while stalled")
   // the divider is quiet whenever a new request can be taken
   `ASSERT_SYNC(a_idle_div, clock, reset, req_ready |-> !status.div_busy, "divider busy while idle")
   // drives read zero when no new drive was computed
   `ASSERT_SYNC(a_drive_gate, clock, reset, (rsp_valid && !rsp_drive_valid) |-> (rsp_left_drive == '0 && rsp_right_drive == '0), "drive not zero without drive_valid")

endmodule

`default_nettype wire

/* rtl/lfps_divider.sv */
// Restoring divider, one quotient bit per cycle, shared by normalise and position.
`default_nettype none

module lfps_divider (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic [lfps_pkg::DIV_D_BITS-1:0]     rem_init,
   input  wire logic [lfps_pkg::DIV_FEED_BITS-1:0]  feed_init,
   input  wire logic [lfps_pkg::DIV_CNT_BITS-1:0]   step_total,
   input  wire logic [lfps_pkg::DIV_D_BITS-1:0]     divisor,
   output logic                                     busy,
   output logic [lfps_pkg::DIV_FEED_BITS-1:0]       quotient
);

   logic [lfps_pkg::DIV_D_BITS-1:0]    rem_ff, rem_in, div_ff;
   logic [lfps_pkg::DIV_FEED_BITS-1:0] feed_ff, feed_in, quot_ff, quot_in;
   logic [lfps_pkg::DIV_CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                               busy_ff, busy_in;
   logic [lfps_pkg::DIV_D_BITS:0]      trial, diff;
   logic                               fits;

   assign trial = {rem_ff, feed_ff[lfps_pkg::DIV_FEED_BITS-1]};
   assign fits  = trial >= {1'b0, div_ff};
   assign diff  = trial - {1'b0, div_ff};

   always_comb begin
      rem_in  = rem_ff;
      feed_in = feed_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = rem_init;
         feed_in = feed_init;
         quot_in = '0;
         cnt_in  = step_total;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[lfps_pkg::DIV_D_BITS-1:0] : trial[lfps_pkg::DIV_D_BITS-1:0];
         feed_in = feed_ff << 1;
         quot_in = {quot_ff[lfps_pkg::DIV_FEED_BITS-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         busy_in = cnt_ff != lfps_pkg::DIV_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      feed_ff <= feed_in;
      quot_ff <= quot_in;
      if (start) div_ff <= divisor;
   end

   assign busy     = busy_ff;
   assign quotient = quot_ff;

endmodule

`default_nettype wire

/* rtl/lfps_datapath.sv */
// Datapath: registers, calibration, normalise, centroid, PID multiplier and result.
`default_nettype none

module lfps_datapath (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    csr_write_enable,
   input  wire logic [lfps_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [lfps_pkg::CSR_DATA_BITS-1:0]      csr_write_data,
   input  wire logic [lfps_pkg::ACTION_BITS-1:0]        req_action,
   input  wire logic [lfps_pkg::READING_BITS-1:0]       req_reading [lfps_pkg::SENSOR_COUNT],
   input  wire lfps_pkg::cmd_type                       cmd,
   output lfps_pkg::status_type                         status,
   output logic                                         rsp_drive_valid,
   output logic [lfps_pkg::DRIVE_BITS-1:0]              rsp_left_drive,
   output logic [lfps_pkg::DRIVE_BITS-1:0]              rsp_right_drive,
   output logic signed [lfps_pkg::POS_BITS-1:0]         rsp_line_position,
   output logic [lfps_pkg::COUNT_BITS-1:0]              rsp_lit_count,
   output logic [lfps_pkg::LAP_BITS-1:0]                rsp_lap_total,
   output logic                                         rsp_lap_pulse
);

   localparam int RB = lfps_pkg::READING_BITS;
   localparam int VB = lfps_pkg::VALUE_BITS;

   // configuration
   logic signed [lfps_pkg::GAIN_BITS-1:0] gp_ff, gi_ff, gd_ff, gr_ff;
   logic [lfps_pkg::DRIVE_BITS-1:0]       base_ff, thr_ff;
   logic                                  dark_ff;

   // item and calibration
   logic [lfps_pkg::ACTION_BITS-1:0] action_ff;
   logic [RB-1:0] rd_ff    [lfps_pkg::SENSOR_COUNT];
   logic [RB-1:0] floor_ff [lfps_pkg::SENSOR_COUNT];
   logic [RB-1:0] line_ff  [lfps_pkg::SENSOR_COUNT];

   // control state
   logic signed [lfps_pkg::POS_BITS-1:0] pn_ff, pp_ff;
   logic [lfps_pkg::COUNT_BITS-1:0]      prev_lit_ff;
   logic [lfps_pkg::LAP_BITS-1:0]        lap_ff;

   // per item work
   logic [lfps_pkg::LIT_BITS-1:0]         lit_ff, lit_in;
   logic                                  stop_ff, stop_in;
   logic signed [lfps_pkg::TSUM_BITS-1:0] tsum_ff;
   logic [lfps_pkg::SUM_BITS-1:0]         sum_ff;
   logic                                  res_valid_ff, pulse_ff;
   logic signed [lfps_pkg::PROD_BITS-1:0] prod_ff, red_prod_ff;
   logic [lfps_pkg::MUL_SEL_BITS-1:0]     prod_sel_ff;
   logic signed [lfps_pkg::ACC_BITS-1:0]  acc_ff;
   logic signed [lfps_pkg::PID_BITS-1:0]  pid_ff;
   logic [lfps_pkg::DRIVE_BITS-1:0]       red_ff;

   // output register
   logic                                 out_valid_ff;
   logic [lfps_pkg::DRIVE_BITS-1:0]      out_left_ff, out_right_ff;
   logic signed [lfps_pkg::POS_BITS-1:0] out_pos_ff;
   logic [lfps_pkg::COUNT_BITS-1:0]      out_lit_ff;
   logic [lfps_pkg::LAP_BITS-1:0]        out_lap_ff;
   logic                                 out_pulse_ff;

   // divider
   logic                                  div_start, div_busy;
   logic [lfps_pkg::DIV_D_BITS-1:0]       div_rem, div_den;
   logic [lfps_pkg::DIV_FEED_BITS-1:0]    div_feed, div_quot;
   logic [lfps_pkg::DIV_CNT_BITS-1:0]     div_steps;

   // normalise
   logic signed [RB:0] num, den;
   logic [RB-1:0]      num_abs, den_abs;
   logic               skip, cap;
   logic [VB-1:0]      v_raw, v;
   logic               on;
   logic signed [lfps_pkg::OFF_BITS-1:0]        off;
   logic signed [VB+lfps_pkg::OFF_BITS:0]       wprod;

   // position
   logic [lfps_pkg::TSUM_BITS-2:0]        t_abs;
   logic [lfps_pkg::PNUM_BITS-1:0]        pnum;
   logic [lfps_pkg::DEN_POS_BITS-1:0]     pden;
   logic [lfps_pkg::POSQ_BITS-1:0]        pq;
   logic [lfps_pkg::POS_BITS-1:0]         pq_cap;
   logic signed [lfps_pkg::POS_BITS-1:0]  pos_new;

   // PID
   logic signed [lfps_pkg::GAIN_BITS-1:0]  mul_a;
   logic signed [lfps_pkg::MUL_B_BITS-1:0] mul_b, pn_x, pp_x, pn_abs, pp_abs;
   logic signed [lfps_pkg::PID_BITS-1:0]   pid_r, red_r;
   logic signed [lfps_pkg::DRV_BITS-1:0]   left_s, right_s;
   logic [lfps_pkg::COUNT_BITS-1:0]        lit_sat;
   logic                                   lap_hit;

   function automatic logic signed [lfps_pkg::PID_BITS-1:0] round_q(
      input logic signed [lfps_pkg::ACC_BITS-1:0] x);
      logic [lfps_pkg::ACC_BITS-1:0] mag;
      logic [lfps_pkg::ACC_BITS-1:0] rq;
      mag = x[lfps_pkg::ACC_BITS-1] ? lfps_pkg::ACC_BITS'(-x) : lfps_pkg::ACC_BITS'(x);
      rq  = (mag + lfps_pkg::ACC_BITS'(lfps_pkg::FULL_SCALE / 2)) >> lfps_pkg::Q_BITS;
      return x[lfps_pkg::ACC_BITS-1] ? -$signed(lfps_pkg::PID_BITS'(rq))
                                     : $signed(lfps_pkg::PID_BITS'(rq));
   endfunction

   function automatic logic [lfps_pkg::DRIVE_BITS-1:0] sat_drive(
      input logic signed [lfps_pkg::DRV_BITS-1:0] x);
      if (x < 0) return '0;
      if (x > lfps_pkg::FULL_SCALE) return lfps_pkg::DRIVE_BITS'(lfps_pkg::FULL_SCALE);
      return lfps_pkg::DRIVE_BITS'(x);
   endfunction

   // normalise the selected sensor
   always_comb begin
      num     = $signed({1'b0, rd_ff[cmd.sensor_sel]}) - $signed({1'b0, floor_ff[cmd.sensor_sel]});
      den     = $signed({1'b0, line_ff[cmd.sensor_sel]}) - $signed({1'b0, floor_ff[cmd.sensor_sel]});
      num_abs = num[RB] ? RB'(-num) : RB'(num);
      den_abs = den[RB] ? RB'(-den) : RB'(den);
      skip    = (den == '0) || (num == '0) || (num[RB] != den[RB]);
      cap     = num_abs >= den_abs;
      if (skip)     v_raw = '0;
      else if (cap) v_raw = VB'(lfps_pkg::FULL_SCALE);
      else          v_raw = {1'b0, div_quot[lfps_pkg::Q_BITS-1:0]};
      v       = dark_ff ? VB'(lfps_pkg::FULL_SCALE) - v_raw : v_raw;
      on      = v >= thr_ff;
      lit_in  = lit_ff + lfps_pkg::LIT_BITS'(on);
      stop_in = stop_ff || (!on && lit_in != '0) || (lit_in >= lfps_pkg::RUN_LIMIT);
      off     = lfps_pkg::OFF_BITS'(int'(cmd.sensor_sel) - lfps_pkg::CENTRE_IDX);
      wprod   = $signed({1'b0, v}) * off;
   end

   // position quotient setup and result
   always_comb begin
      t_abs   = tsum_ff[lfps_pkg::TSUM_BITS-1] ? (lfps_pkg::TSUM_BITS-1)'(-tsum_ff)
                                               : (lfps_pkg::TSUM_BITS-1)'(tsum_ff);
      pnum    = lfps_pkg::PNUM_BITS'(t_abs) * lfps_pkg::PNUM_BITS'(2 * lfps_pkg::FULL_SCALE)
              + lfps_pkg::PNUM_BITS'(sum_ff) * lfps_pkg::PNUM_BITS'(lfps_pkg::SPAN_RATIO);
      pden    = lfps_pkg::DEN_POS_BITS'(sum_ff) * lfps_pkg::DEN_POS_BITS'(2 * lfps_pkg::SPAN_RATIO);
      pq      = div_quot[lfps_pkg::POSQ_BITS-1:0];
      pq_cap  = (pq > lfps_pkg::FULL_SCALE) ? lfps_pkg::POS_BITS'(lfps_pkg::FULL_SCALE)
                                            : lfps_pkg::POS_BITS'(pq);
      pos_new = tsum_ff[lfps_pkg::TSUM_BITS-1] ? -$signed(pq_cap) : $signed(pq_cap);
   end

   always_comb begin
      div_start = cmd.norm_div_start || cmd.pos_div_start;
      if (cmd.pos_div_start) begin
         div_rem   = lfps_pkg::DIV_D_BITS'(pnum >> lfps_pkg::POSQ_BITS);
         div_feed  = lfps_pkg::DIV_FEED_BITS'(pnum[lfps_pkg::POSQ_BITS-1:0])
                     << (lfps_pkg::DIV_FEED_BITS - lfps_pkg::POSQ_BITS);
         div_steps = lfps_pkg::DIV_CNT_BITS'(lfps_pkg::POSQ_BITS);
         div_den   = lfps_pkg::DIV_D_BITS'(pden);
      end else begin
         div_rem   = lfps_pkg::DIV_D_BITS'(num_abs);
         div_feed  = '0;
         div_steps = lfps_pkg::DIV_CNT_BITS'(lfps_pkg::Q_BITS);
         div_den   = lfps_pkg::DIV_D_BITS'(den_abs);
      end
   end

   lfps_divider u_divider (
      .clock      (clock),
      .reset      (reset),
      .start      (div_start),
      .rem_init   (div_rem),
      .feed_init  (div_feed),
      .step_total (div_steps),
      .divisor    (div_den),
      .busy       (div_busy),
      .quotient   (div_quot)
   );

   // multiplier operand select
   always_comb begin
      pn_x   = lfps_pkg::MUL_B_BITS'(pn_ff);
      pp_x   = lfps_pkg::MUL_B_BITS'(pp_ff);
      pn_abs = pn_x[lfps_pkg::MUL_B_BITS-1] ? -pn_x : pn_x;
      pp_abs = pp_x[lfps_pkg::MUL_B_BITS-1] ? -pp_x : pp_x;
      case (cmd.mul_sel)
         lfps_pkg::MUL_P: begin mul_a = gp_ff; mul_b = pn_x;            end
         lfps_pkg::MUL_I: begin mul_a = gi_ff; mul_b = pp_x + pn_x;     end
         lfps_pkg::MUL_D: begin mul_a = gd_ff; mul_b = pn_x - pp_x;     end
         lfps_pkg::MUL_R: begin mul_a = gr_ff; mul_b = pp_abs + pn_abs; end
         default:         begin mul_a = gp_ff; mul_b = pn_x;            end
      endcase
   end

   always_comb begin
      pid_r   = round_q(acc_ff);
      red_r   = round_q(lfps_pkg::ACC_BITS'(red_prod_ff));
      left_s  = lfps_pkg::DRV_BITS'($signed({1'b0, base_ff})) - lfps_pkg::DRV_BITS'(pid_ff)
              - lfps_pkg::DRV_BITS'($signed({1'b0, red_ff}));
      right_s = lfps_pkg::DRV_BITS'($signed({1'b0, base_ff})) + lfps_pkg::DRV_BITS'(pid_ff)
              - lfps_pkg::DRV_BITS'($signed({1'b0, red_ff}));
      lit_sat = (lit_ff > lfps_pkg::LIT_MAX) ? lfps_pkg::COUNT_BITS'(lfps_pkg::LIT_MAX)
                                             : lfps_pkg::COUNT_BITS'(lit_ff);
      lap_hit = (prev_lit_ff < lfps_pkg::LAP_LIT) && (lit_ff >= lfps_pkg::LAP_LIT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gp_ff       <= lfps_pkg::RESET_GAIN_P;
         gi_ff       <= '0;
         gd_ff       <= '0;
         gr_ff       <= '0;
         base_ff     <= lfps_pkg::RESET_BASE;
         thr_ff      <= lfps_pkg::RESET_THRESHOLD;
         dark_ff     <= 1'b0;
         pn_ff       <= '0;
         pp_ff       <= '0;
         prev_lit_ff <= '0;
         lap_ff      <= '0;
         for (int i = 0; i < lfps_pkg::SENSOR_COUNT; i++) begin
            floor_ff[i] <= '0;
            line_ff[i]  <= '0;
         end
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               lfps_pkg::CSR_GAIN_P:    gp_ff   <= $signed(csr_write_data);
               lfps_pkg::CSR_GAIN_I:    gi_ff   <= $signed(csr_write_data);
               lfps_pkg::CSR_GAIN_D:    gd_ff   <= $signed(csr_write_data);
               lfps_pkg::CSR_GAIN_R:    gr_ff   <= $signed(csr_write_data);
               lfps_pkg::CSR_BASE:      base_ff <= csr_write_data[lfps_pkg::DRIVE_BITS-1:0];
               lfps_pkg::CSR_THRESHOLD: thr_ff  <= csr_write_data[lfps_pkg::DRIVE_BITS-1:0];
               lfps_pkg::CSR_DARK:      dark_ff <= csr_write_data[0];
               default: ;
            endcase
         end
         if (cmd.capture) begin
            for (int i = 0; i < lfps_pkg::SENSOR_COUNT; i++) begin
               if (action_ff == lfps_pkg::ACT_FLOOR) floor_ff[i] <= rd_ff[i];
               else                                  line_ff[i]  <= rd_ff[i];
            end
         end
         if (cmd.decide) begin
            prev_lit_ff <= lit_sat;
            if (lap_hit) lap_ff <= lap_ff + 1'b1;
         end
         if (cmd.pos_done) begin
            pp_ff <= pn_ff;
            pn_ff <= pos_new;
         end
      end

      // item work registers, no reset needed
      if (cmd.load_item) begin
         action_ff    <= req_action;
         rd_ff        <= req_reading;
         lit_ff       <= '0;
         stop_ff      <= 1'b0;
         tsum_ff      <= '0;
         sum_ff       <= '0;
         res_valid_ff <= 1'b0;
         pulse_ff     <= 1'b0;
      end
      if (cmd.norm_acc) begin
         lit_ff  <= lit_in;
         stop_ff <= stop_in;
         if (!stop_in) begin
            tsum_ff <= tsum_ff + lfps_pkg::TSUM_BITS'(wprod);
            sum_ff  <= sum_ff + lfps_pkg::SUM_BITS'(v);
         end
      end
      if (cmd.decide) pulse_ff <= lap_hit;
      if (cmd.pos_done) begin
         res_valid_ff <= 1'b1;
         acc_ff       <= '0;
      end
      if (cmd.mul_issue) begin
         prod_ff     <= mul_a * mul_b;
         prod_sel_ff <= cmd.mul_sel;
      end
      if (cmd.mul_accum) begin
         if (prod_sel_ff == lfps_pkg::MUL_R) red_prod_ff <= prod_ff;
         else acc_ff <= acc_ff + lfps_pkg::ACC_BITS'(prod_ff);
      end
      if (cmd.round) begin
         pid_ff <= pid_r;
         if (red_r < 0)                                  red_ff <= '0;
         else if (red_r > $signed({1'b0, base_ff}))      red_ff <= base_ff;
         else                                            red_ff <= lfps_pkg::DRIVE_BITS'(red_r);
      end
      if (cmd.out_load) begin
         out_valid_ff <= res_valid_ff;
         out_left_ff  <= res_valid_ff ? sat_drive(left_s) : '0;
         out_right_ff <= res_valid_ff ? sat_drive(right_s) : '0;
         out_pos_ff   <= pn_ff;
         out_lit_ff   <= lit_sat;
         out_lap_ff   <= lap_ff;
         out_pulse_ff <= pulse_ff;
      end
   end

   always_comb begin
      status.action   = action_ff;
      status.need_div = !skip && !cap;
      status.div_busy = div_busy;
      status.run_ok   = (lit_ff < lfps_pkg::RUN_LIMIT) && (sum_ff != '0);
   end

   assign rsp_drive_valid   = out_valid_ff;
   assign rsp_left_drive    = out_left_ff;
   assign rsp_right_drive   = out_right_ff;
   assign rsp_line_position = out_pos_ff;
   assign rsp_lit_count     = out_lit_ff;
   assign rsp_lap_total     = out_lap_ff;
   assign rsp_lap_pulse     = out_pulse_ff;

endmodule

`default_nettype wire

/* rtl/lfps_controller.sv */
// Controller: sequences capture, per-sensor normalise, position, PID and result beat.
`default_nettype none

module lfps_controller (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  rsp_ready,
   output logic                       rsp_valid,
   input  wire lfps_pkg::status_type  status,
   output lfps_pkg::cmd_type          cmd
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_SETUP, ST_NORM_CHECK, ST_NORM_DIV, ST_NORM_ACC, ST_DECIDE,
      ST_POS_DIV, ST_POS_DONE, ST_MUL, ST_ROUND, ST_EMIT
   } state_type;

   state_type                                state_ff, state_in;
   logic [lfps_pkg::SENSOR_IDX_BITS-1:0]     sensor_ff, sensor_in;
   logic [lfps_pkg::MUL_CNT_BITS-1:0]        mul_cnt_ff, mul_cnt_in;
   logic                                     rsp_valid_ff, rsp_valid_in;
   logic                                     out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in       = state_ff;
      sensor_in      = sensor_ff;
      mul_cnt_in     = mul_cnt_ff;
      cmd            = '0;
      cmd.sensor_sel = sensor_ff;
      cmd.mul_sel    = mul_cnt_ff[lfps_pkg::MUL_SEL_BITS-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_SETUP;
            end
         end
         ST_SETUP: begin
            case (status.action)
               lfps_pkg::ACT_CONTROL: begin
                  sensor_in = '0;
                  state_in  = ST_NORM_CHECK;
               end
               lfps_pkg::ACT_FLOOR, lfps_pkg::ACT_LINE: begin
                  cmd.capture = 1'b1;
                  state_in    = ST_EMIT;
               end
               default: state_in = ST_EMIT;
            endcase
         end
         ST_NORM_CHECK: begin
            if (status.need_div) begin
               cmd.norm_div_start = 1'b1;
               state_in           = ST_NORM_DIV;
            end else begin
               state_in = ST_NORM_ACC;
            end
         end
         ST_NORM_DIV: begin
            if (!status.div_busy) state_in = ST_NORM_ACC;
         end
         ST_NORM_ACC: begin
            cmd.norm_acc = 1'b1;
            if (sensor_ff == lfps_pkg::SENSOR_IDX_BITS'(lfps_pkg::SENSOR_COUNT - 1)) begin
               state_in = ST_DECIDE;
            end else begin
               sensor_in = sensor_ff + 1'b1;
               state_in  = ST_NORM_CHECK;
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            if (status.run_ok) begin
               cmd.pos_div_start = 1'b1;
               state_in          = ST_POS_DIV;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_POS_DIV: begin
            if (!status.div_busy) state_in = ST_POS_DONE;
         end
         ST_POS_DONE: begin
            cmd.pos_done = 1'b1;
            mul_cnt_in   = '0;
            state_in     = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_issue = mul_cnt_ff < lfps_pkg::MUL_TERMS;
            cmd.mul_accum = mul_cnt_ff != '0;
            if (mul_cnt_ff == lfps_pkg::MUL_CNT_BITS'(lfps_pkg::MUL_TERMS)) begin
               state_in = ST_ROUND;
            end else begin
               mul_cnt_in = mul_cnt_ff + 1'b1;
            end
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = (rsp_valid_ff && !rsp_ready) || cmd.out_load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sensor_ff    <= '0;
         mul_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sensor_ff    <= sensor_in;
         mul_cnt_ff   <= mul_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

/* tb/tb.sv */
// Testbench for the line follower steering block: directed and random steps checked against a predictor.
`timescale 1ns / 1ps

module tb;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [lfps_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [lfps_pkg::CSR_DATA_BITS-1:0] csr_write_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [lfps_pkg::ACTION_BITS-1:0] req_action = '0;
   logic [lfps_pkg::READING_BITS-1:0] req_reading_0 = '0, req_reading_1 = '0,
                                      req_reading_2 = '0, req_reading_3 = '0,
                                      req_reading_4 = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_drive_valid;
   logic [lfps_pkg::DRIVE_BITS-1:0] rsp_left_drive, rsp_right_drive;
   logic signed [lfps_pkg::POS_BITS-1:0] rsp_line_position;
   logic [lfps_pkg::COUNT_BITS-1:0] rsp_lit_count;
   logic [lfps_pkg::LAP_BITS-1:0] rsp_lap_total;
   logic rsp_lap_pulse;

   line_follower_pid_steering dut (.*);

   always #2 clock = ~clock;

   typedef struct packed {
      logic                                 drive_valid;
      logic [lfps_pkg::DRIVE_BITS-1:0]      left_drive;
      logic [lfps_pkg::DRIVE_BITS-1:0]      right_drive;
      logic signed [lfps_pkg::POS_BITS-1:0] line_position;
      logic [lfps_pkg::COUNT_BITS-1:0]      lit_count;
      logic [lfps_pkg::LAP_BITS-1:0]        lap_total;
      logic                                 lap_pulse;
   } steer_type;

   typedef logic [lfps_pkg::READING_BITS-1:0] reading_type;

   // predictor copy of the registers and state
   longint gain_p, gain_i, gain_d, gain_r;
   longint base_q, thresh_q;
   bit     dark_q;
   longint floor_q[lfps_pkg::SENSOR_COUNT], line_q[lfps_pkg::SENSOR_COUNT];
   longint pos_now, pos_prev;
   int     last_lit;
   int     laps;

   steer_type steer_expected[$];
   int        errors = 0;
   longint    cycles = 0;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 3000000) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic report(input string what, input longint got, input longint want);
      errors++;
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
   endtask

   function automatic longint round_div(longint n, longint d);
      longint m;
      m = n < 0 ? -n : n;
      m = (m + d / 2) / d;
      return n < 0 ? -m : m;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint norm_reading(longint r, longint lo, longint hi);
      longint num, den;
      num = r - lo;
      den = hi - lo;
      if (den == 0 || num == 0 || ((num < 0) != (den < 0))) return 0;
      if (num < 0) begin
         num = -num;
         den = -den;
      end
      return clip(num * lfps_pkg::FULL_SCALE / den, 0, lfps_pkg::FULL_SCALE);
   endfunction

   function automatic steer_type steer_predict(logic [lfps_pkg::ACTION_BITS-1:0] act,
                                               reading_type rd[lfps_pkg::SENSOR_COUNT]);
      steer_type o;
      longint wsum, vsum, v, pid, red, acc, ap, an, pos;
      int lit;
      bit halt, on;
      o = '0;
      lit = 0;
      wsum = 0;
      vsum = 0;
      halt = 0;
      if (act == lfps_pkg::ACT_FLOOR || act == lfps_pkg::ACT_LINE) begin
         for (int i = 0; i < lfps_pkg::SENSOR_COUNT; i++)
            if (act == lfps_pkg::ACT_FLOOR) floor_q[i] = longint'(rd[i]);
            else line_q[i] = longint'(rd[i]);
      end else if (act == lfps_pkg::ACT_CONTROL) begin
         for (int i = 0; i < lfps_pkg::SENSOR_COUNT; i++) begin
            v = norm_reading(longint'(rd[i]), floor_q[i], line_q[i]);
            if (dark_q) v = lfps_pkg::FULL_SCALE - v;
            on = v >= thresh_q;
            if (on) lit++;
            if ((!on && lit > 0) || lit > 2) halt = 1;
            if (!halt) begin
               wsum += v * (i + 1) * lfps_pkg::WEIGHT_STEP;
               vsum += v;
            end
         end
         if (lit < 3) begin
            if (vsum > 0) begin
               pos = round_div((wsum - lfps_pkg::CENTRE_POS * vsum) * lfps_pkg::FULL_SCALE,
                               lfps_pkg::HALF_SPAN * vsum);
               pos_prev = pos_now;
               pos_now = clip(pos, -lfps_pkg::FULL_SCALE, lfps_pkg::FULL_SCALE);
               acc = gain_p * pos_now + gain_i * (pos_prev + pos_now)
                   + gain_d * (pos_now - pos_prev);
               pid = round_div(acc, lfps_pkg::FULL_SCALE);
               ap = pos_prev < 0 ? -pos_prev : pos_prev;
               an = pos_now < 0 ? -pos_now : pos_now;
               red = clip(round_div(gain_r * (ap + an), lfps_pkg::FULL_SCALE), 0, base_q);
               o.left_drive = lfps_pkg::DRIVE_BITS'(
                  clip(base_q - pid - red, 0, lfps_pkg::FULL_SCALE));
               o.right_drive = lfps_pkg::DRIVE_BITS'(
                  clip(base_q + pid - red, 0, lfps_pkg::FULL_SCALE));
               o.drive_valid = 1'b1;
            end
         end else if (last_lit < 4 && lit >= 4) begin
            laps = (laps + 1) & 8'hFF;
            o.lap_pulse = 1'b1;
         end
         if (lit > 7) lit = 7;
         last_lit = lit;
         o.lit_count = lfps_pkg::COUNT_BITS'(lit);
      end
      o.line_position = lfps_pkg::POS_BITS'(pos_now);
      o.lap_total = lfps_pkg::LAP_BITS'(laps);
      return o;
   endfunction

   // random gap length: mostly short, sometimes long
   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   bit rsp_stall_on = 1;

   // result receiver: random back-pressure, compares each beat
   always @(posedge clock) begin
      steer_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (steer_expected.size() == 0) begin
            report("unexpected beat", 0, 0);
         end else begin
            want = steer_expected.pop_front();
            if (rsp_drive_valid !== want.drive_valid)
               report("drive_valid", rsp_drive_valid, want.drive_valid);
            if (rsp_left_drive !== want.left_drive)
               report("left_drive", rsp_left_drive, want.left_drive);
            if (rsp_right_drive !== want.right_drive)
               report("right_drive", rsp_right_drive, want.right_drive);
            if (rsp_line_position !== want.line_position)
               report("line_position", rsp_line_position, want.line_position);
            if (rsp_lit_count !== want.lit_count)
               report("lit_count", rsp_lit_count, want.lit_count);
            if (rsp_lap_total !== want.lap_total)
               report("lap_total", rsp_lap_total, want.lap_total);
            if (rsp_lap_pulse !== want.lap_pulse)
               report("lap_pulse", rsp_lap_pulse, want.lap_pulse);
         end
      end
   end

   int rsp_hold = 0;
   always @(posedge clock) begin
      if (reset || !rsp_stall_on) begin
         rsp_ready <= 1'b1;
      end else if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_hold <= gap_len();
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   bit req_gaps_on = 1;

   // send one request beat; prediction is made at acceptance
   task automatic send_beat(input logic [lfps_pkg::ACTION_BITS-1:0] act,
                            input reading_type rd[lfps_pkg::SENSOR_COUNT]);
      int g;
      g = req_gaps_on ? gap_len() : 0;
      // first edge lets the drop of valid from the previous beat take effect
      repeat (g + 1) @(posedge clock);
      req_valid <= 1'b1;
      req_action <= act;
      req_reading_0 <= rd[0];
      req_reading_1 <= rd[1];
      req_reading_2 <= rd[2];
      req_reading_3 <= rd[3];
      req_reading_4 <= rd[4];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      steer_expected.push_back(steer_predict(act, rd));
      req_valid <= 1'b0;
   endtask

   task automatic send_all(input logic [lfps_pkg::ACTION_BITS-1:0] act, input int val);
      reading_type rd[lfps_pkg::SENSOR_COUNT];
      foreach (rd[i]) rd[i] = reading_type'(val);
      send_beat(act, rd);
   endtask

   task automatic drain();
      while (steer_expected.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic csr_write(input logic [lfps_pkg::CSR_INDEX_BITS-1:0] idx,
                            input longint val);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val[lfps_pkg::CSR_DATA_BITS-1:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         lfps_pkg::CSR_GAIN_P: gain_p = $signed(val[15:0]);
         lfps_pkg::CSR_GAIN_I: gain_i = $signed(val[15:0]);
         lfps_pkg::CSR_GAIN_D: gain_d = $signed(val[15:0]);
         lfps_pkg::CSR_GAIN_R: gain_r = $signed(val[15:0]);
         lfps_pkg::CSR_BASE: base_q = val[12:0];
         lfps_pkg::CSR_THRESHOLD: thresh_q = val[12:0];
         lfps_pkg::CSR_DARK: dark_q = val[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // readings: fully random (shape 0), a lit run of width 1..3 at a random spot (shape 1), or lit middle, dark ends
   task automatic send_line_step(input int shape);
      reading_type rd[lfps_pkg::SENSOR_COUNT];
      int c, w;
      c = $urandom_range(0, lfps_pkg::SENSOR_COUNT - 1);
      w = $urandom_range(1, 3);
      foreach (rd[i]) begin
         if (shape == 0) rd[i] = reading_type'($urandom());
         else if (shape == 1)
            rd[i] = (i >= c && i < c + w) ? reading_type'($urandom_range(700, 1023))
                                          : reading_type'($urandom_range(0, 500));
         else
            rd[i] = (i == 0 || i == lfps_pkg::SENSOR_COUNT - 1)
                    ? reading_type'($urandom_range(0, 300))
                    : reading_type'($urandom_range(600, 1023));
      end
      send_beat(lfps_pkg::ACT_CONTROL, rd);
   endtask

   task automatic test_reset_defaults();
      send_all(lfps_pkg::ACT_CONTROL, 0);
      send_all(lfps_pkg::ACT_CONTROL, 1023);
      send_all(lfps_pkg::ACT_UNUSED, 512);
   endtask

   task automatic test_calibration_cases();
      reading_type rd[lfps_pkg::SENSOR_COUNT];
      send_all(lfps_pkg::ACT_FLOOR, 100);
      send_all(lfps_pkg::ACT_LINE, 900);
      send_all(lfps_pkg::ACT_CONTROL, 100);
      send_all(lfps_pkg::ACT_CONTROL, 900);
      send_all(lfps_pkg::ACT_CONTROL, 1023);
      rd = '{1023, 100, 100, 100, 100};
      send_beat(lfps_pkg::ACT_CONTROL, rd);
      rd = '{100, 100, 100, 100, 1023};
      send_beat(lfps_pkg::ACT_CONTROL, rd);
      rd = '{100, 900, 500, 100, 900};
      send_beat(lfps_pkg::ACT_CONTROL, rd);
      // reversed bounds
      send_all(lfps_pkg::ACT_FLOOR, 1023);
      send_all(lfps_pkg::ACT_LINE, 0);
      rd = '{0, 200, 1023, 800, 600};
      send_beat(lfps_pkg::ACT_CONTROL, rd);
      send_all(lfps_pkg::ACT_UNUSED, 0);
      // equal bounds give zero everywhere
      send_all(lfps_pkg::ACT_LINE, 1023);
      send_all(lfps_pkg::ACT_CONTROL, 5);
      send_all(lfps_pkg::ACT_FLOOR, 0);
      send_all(lfps_pkg::ACT_LINE, 1023);
      drain();
   endtask

   task automatic test_config_extremes();
      reading_type rd[lfps_pkg::SENSOR_COUNT];
      csr_write(lfps_pkg::CSR_DARK, 1);
      csr_write(lfps_pkg::CSR_GAIN_I, 16'h7FFF);
      csr_write(lfps_pkg::CSR_GAIN_D, 16'h8000);
      csr_write(lfps_pkg::CSR_GAIN_R, 16'h7FFF);
      csr_write(lfps_pkg::CSR_BASE, 4096);
      csr_write(lfps_pkg::CSR_THRESHOLD, 4096);
      rd = '{0, 1023, 1023, 1023, 1023};
      send_beat(lfps_pkg::ACT_CONTROL, rd);
      rd = '{1023, 1023, 1023, 1023, 0};
      send_beat(lfps_pkg::ACT_CONTROL, rd);
      drain();
      csr_write(lfps_pkg::CSR_DARK, 0);
      csr_write(lfps_pkg::CSR_GAIN_P, 16'h8000);
      csr_write(lfps_pkg::CSR_BASE, 8191);
      csr_write(lfps_pkg::CSR_THRESHOLD, 8191);
      send_all(lfps_pkg::ACT_CONTROL, 1023);
      drain();
      csr_write(lfps_pkg::CSR_THRESHOLD, 0);
      csr_write(lfps_pkg::CSR_BASE, 0);
      send_all(lfps_pkg::ACT_CONTROL, 1023);
      send_all(lfps_pkg::ACT_CONTROL, 512);
      drain();
   endtask

   task automatic test_random_steering(input int n);
      for (int k = 0; k < n; k++) begin
         if (k % 250 == 0) begin
            drain();
            csr_write(lfps_pkg::CSR_GAIN_P, $urandom());
            csr_write(lfps_pkg::CSR_GAIN_I, $urandom_range(0, 3) == 0 ? $urandom() : 0);
            csr_write(lfps_pkg::CSR_GAIN_D, $urandom_range(0, 1) ? $urandom() : 0);
            csr_write(lfps_pkg::CSR_GAIN_R, $urandom_range(0, 1) ? $urandom() : 0);
            csr_write(lfps_pkg::CSR_BASE,
                      $urandom_range(0, 4) == 0 ? $urandom() : $urandom_range(0, 4096));
            csr_write(lfps_pkg::CSR_THRESHOLD, $urandom_range(1000, 3500));
            csr_write(lfps_pkg::CSR_DARK, $urandom_range(0, 1));
            send_all(lfps_pkg::ACT_FLOOR, 0);
            send_all(lfps_pkg::ACT_LINE, 1023);
            // no idling at all for the stretch that starts at k == 500
            req_gaps_on = (k != 500);
            rsp_stall_on = (k != 500);
         end
         case ($urandom_range(0, 19))
            0: send_line_step(0);
            1: send_line_step(2);
            2: begin
               reading_type rd[lfps_pkg::SENSOR_COUNT];
               foreach (rd[i]) rd[i] = reading_type'($urandom());
               send_beat($urandom_range(0, 3) == 0
                         ? lfps_pkg::ACT_UNUSED
                         : ($urandom_range(0, 1) ? lfps_pkg::ACT_FLOOR : lfps_pkg::ACT_LINE),
                         rd);
            end
            default: send_line_step(1);
         endcase
         if (k % 50 == 49) begin
            req_gaps_on = 1;
            rsp_stall_on = 1;
         end
      end
   endtask

   initial begin
      gain_p = 2048; gain_i = 0; gain_d = 0; gain_r = 0;
      base_q = 2458; thresh_q = 2048; dark_q = 0;
      foreach (floor_q[i]) begin
         floor_q[i] = 0;
         line_q[i] = 0;
      end
      pos_now = 0; pos_prev = 0; last_lit = 0; laps = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_calibration_cases();
      test_config_extremes();
      test_random_steering(1250);
      drain();
      if (errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl
rtl/lfps_pkg.sv
rtl/lfps_divider.sv
rtl/lfps_datapath.sv
rtl/lfps_controller.sv
rtl/line_follower_pid_steering.sv
tb/tb.sv
